// ----- hw/rtl/bfba_pkg.sv -----
package bfba_pkg;

  // field widths
  localparam int unsigned OP_W   = 1;
  localparam int unsigned REQ_W  = 19;
  localparam int unsigned OFF_W  = 18;
  localparam int unsigned GB_W   = 19;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned BC_W   = 11;

  localparam logic [BC_W-1:0] BC_RESET = 11'd1024;

  localparam logic [OP_W-1:0] OP_ALLOC   = 1'b0;
  localparam logic [OP_W-1:0] OP_RELEASE = 1'b1;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_NO_FIT  = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD_REQ = 2'd2;
  localparam logic [ST_W-1:0] ST_BAD_REL = 2'd3;

  // map read address select
  localparam logic [1:0] RD_IDX  = 2'd0;
  localparam logic [1:0] RD_B    = 2'd1;
  localparam logic [1:0] RD_BM1  = 2'd2;
  localparam logic [1:0] RD_BASE = 2'd3;

  typedef struct packed {
    logic            clr_start;
    logic            clr_step;
    logic            take;
    logic            div_step;
    logic            srch_start;
    logic            srch_eval;
    logic            alloc_setup;
    logic            split_setup;
    logic            mark_step;
    logic            cap_b;
    logic            cap_base;
    logic            add_base;
    logic            rel_setup;
    logic            rel_merge;
    logic            set_status;
    logic [ST_W-1:0] status_val;
    logic            load_out;
    logic [1:0]      rd_sel;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic is_release;
    logic bad_req;
    logic bad_off;
    logic idx_ge_n;
    logic found;
    logic mark_done;
    logic split_need;
    logic bad_rel;
    logic prev_free;
    logic out_free;
  } sts_t;

endpackage

// ----- hw/rtl/bfba_ram.sv -----
module bfba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hw/rtl/bfba_ctrl.sv -----
module bfba_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bfba_pkg::sts_t  sts_i,
  input  logic            cfg_we_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output bfba_pkg::cmd_t  cmd_o
);
  import bfba_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_CHECK = 4'd3;
  localparam logic [3:0] S_SRD   = 4'd4;
  localparam logic [3:0] S_SEVAL = 4'd5;
  localparam logic [3:0] S_SDEC  = 4'd6;
  localparam logic [3:0] S_AMARK = 4'd7;
  localparam logic [3:0] S_FMARK = 4'd8;
  localparam logic [3:0] S_RRD   = 4'd9;
  localparam logic [3:0] S_RRDM1 = 4'd10;
  localparam logic [3:0] S_REVAL = 4'd11;
  localparam logic [3:0] S_RADD  = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;

  logic [3:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_sel = RD_IDX;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.is_release) begin
          if (sts_i.bad_off) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status_val = ST_BAD_REL;
            state_d          = S_DONE;
          end else begin
            state_d = S_RRD;
          end
        end else if (sts_i.bad_req) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status_val = ST_BAD_REQ;
          state_d          = S_DONE;
        end else begin
          cmd_o.srch_start = 1'b1;
          state_d          = S_SRD;
        end
      end
      S_SRD: begin
        if (sts_i.idx_ge_n) state_d = S_SDEC;
        else state_d = S_SEVAL;
      end
      S_SEVAL: begin
        cmd_o.srch_eval = 1'b1;
        state_d         = S_SRD;
      end
      S_SDEC: begin
        cmd_o.set_status = 1'b1;
        if (sts_i.found) begin
          cmd_o.alloc_setup = 1'b1;
          cmd_o.status_val  = ST_OK;
          state_d           = S_AMARK;
        end else begin
          cmd_o.status_val = ST_NO_FIT;
          state_d          = S_DONE;
        end
      end
      S_AMARK: begin
        if (!sts_i.mark_done) begin
          cmd_o.mark_step = 1'b1;
        end else if (sts_i.split_need) begin
          cmd_o.split_setup = 1'b1;
          state_d           = S_FMARK;
        end else begin
          state_d = S_DONE;
        end
      end
      S_FMARK: begin
        if (!sts_i.mark_done) cmd_o.mark_step = 1'b1;
        else state_d = S_DONE;
      end
      S_RRD: begin
        cmd_o.rd_sel = RD_B;
        state_d      = S_RRDM1;
      end
      S_RRDM1: begin
        cmd_o.rd_sel = RD_BM1;
        cmd_o.cap_b  = 1'b1;
        state_d      = S_REVAL;
      end
      S_REVAL: begin
        cmd_o.set_status = 1'b1;
        if (sts_i.bad_rel) begin
          cmd_o.status_val = ST_BAD_REL;
          state_d          = S_DONE;
        end else if (sts_i.prev_free) begin
          cmd_o.status_val = ST_OK;
          cmd_o.cap_base   = 1'b1;
          cmd_o.rd_sel     = RD_BASE;
          state_d          = S_RADD;
        end else begin
          cmd_o.status_val = ST_OK;
          cmd_o.rel_setup  = 1'b1;
          state_d          = S_FMARK;
        end
      end
      S_RADD: begin
        cmd_o.add_base  = 1'b1;
        cmd_o.rel_setup = 1'b1;
        cmd_o.rel_merge = 1'b1;
        state_d         = S_FMARK;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
    // a register write rebuilds the map from scratch
    if (cfg_we_i) begin
      cmd_o           = '0;
      cmd_o.clr_start = 1'b1;
      state_d         = S_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hw/rtl/bfba_datapath.sv -----
module bfba_datapath #(
  parameter int unsigned MAX_BLOCKS  = 1024,
  parameter int unsigned BLOCK_BYTES = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bfba_pkg::cmd_t                cmd_i,
  output bfba_pkg::sts_t                sts_o,
  input  logic                          cfg_we_i,
  input  logic [bfba_pkg::BC_W-1:0]     cfg_data_i,
  input  logic [bfba_pkg::OP_W-1:0]     op_i,
  input  logic [bfba_pkg::REQ_W-1:0]    request_bytes_i,
  input  logic [bfba_pkg::OFF_W-1:0]    release_offset_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [bfba_pkg::ST_W-1:0]     status_o,
  output logic [bfba_pkg::OFF_W-1:0]    grant_offset_o,
  output logic [bfba_pkg::GB_W-1:0]     grant_bytes_o
);
  import bfba_pkg::*;

  localparam int unsigned IW  = $clog2(MAX_BLOCKS);
  localparam int unsigned LW  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned XW  = LW + 1;
  localparam int unsigned RW  = $clog2(BLOCK_BYTES + 1) + 1;
  localparam int unsigned DW  = REQ_W;
  localparam int unsigned DCW = 1;
  localparam int unsigned FSW = IW + 1;
  localparam int unsigned PW  = LW + 17;
  // reciprocal of the block size, exact for every DW-bit dividend
  localparam int unsigned LG  = $clog2(BLOCK_BYTES);
  localparam int unsigned MW  = DW + 1;
  localparam int unsigned QPW = DW + MW;
  localparam int unsigned BPW = DW + 17;
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << (DW + LG)) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES));

  logic [BC_W-1:0]  bc_q;
  logic [OP_W-1:0]  op_q;
  logic             zero_q;
  logic [DW-1:0]    dvd_q, quo_q;
  logic [RW-1:0]    rem_q;
  logic [DCW-1:0]   dcnt_q;
  logic [XW-1:0]    idx_q, end_q;
  logic [IW-1:0]    best_start_q;
  logic [LW-1:0]    best_len_q;
  logic             found_q;
  logic             b_free_q;
  logic [IW-1:0]    b_start_q;
  logic [LW-1:0]    rel_len_q;
  logic [IW-1:0]    base_q;
  logic             mk_free_q;
  logic [IW-1:0]    mk_base_q;
  logic [ST_W-1:0]  st_q;
  logic             out_valid_q;
  logic [ST_W-1:0]  out_status_q;
  logic [OFF_W-1:0] out_off_q;
  logic [GB_W-1:0]  out_bytes_q;

  logic [LW-1:0]    n;
  logic [DW:0]      need;
  logic [LW-1:0]    req;
  logic [IW-1:0]    b;
  logic [FSW-1:0]   fs_rd;
  logic [LW-1:0]    len_rd;
  logic             fs_rd_free;
  logic [IW-1:0]    fs_rd_start;
  logic [IW-1:0]    raddr;
  logic             fs_we, len_we;
  logic [IW-1:0]    fs_waddr, len_waddr;
  logic [FSW-1:0]   fs_wdata;
  logic [LW-1:0]    len_wdata;
  logic             mark_go;
  logic [XW-1:0]    rest;
  logic [QPW-1:0]   quo_prod;
  logic [DW-1:0]    quo_nx;
  logic [BPW-1:0]   back_prod;
  logic [DW-1:0]    rem_full;
  logic             cand;
  logic [XW-1:0]    step;

  always_comb begin
    if (bc_q == '0) n = LW'(1);
    else if (32'(bc_q) > 32'(MAX_BLOCKS)) n = LW'(MAX_BLOCKS);
    else n = LW'(bc_q);
  end

  assign need        = {1'b0, quo_q} + (DW+1)'(rem_q != '0);
  assign req         = LW'(need);
  assign b           = quo_q[IW-1:0];
  assign fs_rd_free  = fs_rd[IW];
  assign fs_rd_start = fs_rd[IW-1:0];
  assign mark_go     = (idx_q < end_q) && (idx_q < XW'(MAX_BLOCKS));
  assign rest        = XW'(best_start_q) + XW'(req);
  // quotient first, remainder from it on the following cycle
  assign quo_prod    = QPW'(dvd_q) * QPW'(RECIP);
  assign quo_nx      = DW'(quo_prod >> (DW + LG));
  assign back_prod   = BPW'(quo_q) * BPW'(BLOCK_BYTES);
  assign rem_full    = dvd_q - DW'(back_prod);
  assign cand        = fs_rd_free && (len_rd >= req) && (!found_q || (len_rd < best_len_q));
  assign step        = (len_rd == '0) ? XW'(1) : XW'(len_rd);

  always_comb begin
    sts_o.clr_last   = (idx_q == XW'(MAX_BLOCKS - 1));
    sts_o.div_last   = (dcnt_q == DCW'(1));
    sts_o.is_release = (op_q == OP_RELEASE);
    sts_o.bad_req    = zero_q || (32'(need) > 32'(n));
    sts_o.bad_off    = (rem_q != '0) || (32'(quo_q) >= 32'(n));
    sts_o.idx_ge_n   = (idx_q >= XW'(n));
    sts_o.found      = found_q;
    sts_o.mark_done  = !mark_go;
    sts_o.split_need = (best_len_q > req);
    sts_o.bad_rel    = b_free_q || (b_start_q != b);
    sts_o.prev_free  = (b != '0) && fs_rd_free;
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

  always_comb begin
    case (cmd_i.rd_sel)
      RD_B:    raddr = b;
      RD_BM1:  raddr = b - IW'(1);
      RD_BASE: raddr = fs_rd_start;
      default: raddr = idx_q[IW-1:0];
    endcase
  end

  always_comb begin
    fs_we     = 1'b0;
    fs_waddr  = idx_q[IW-1:0];
    fs_wdata  = {mk_free_q, mk_base_q};
    len_we    = 1'b0;
    len_waddr = idx_q[IW-1:0];
    len_wdata = '0;
    if (cmd_i.clr_step) begin
      fs_we     = 1'b1;
      fs_wdata  = {1'b1, {IW{1'b0}}};
      len_we    = 1'b1;
      len_wdata = (idx_q == '0) ? n : '0;
    end
    if (cmd_i.mark_step && mark_go) fs_we = 1'b1;
    if (cmd_i.alloc_setup) begin
      len_we    = 1'b1;
      len_waddr = best_start_q;
      len_wdata = req;
    end
    if (cmd_i.split_setup) begin
      len_we    = (rest < XW'(MAX_BLOCKS));
      len_waddr = rest[IW-1:0];
      len_wdata = best_len_q - req;
    end
    if (cmd_i.add_base) begin
      len_we    = 1'b1;
      len_waddr = base_q;
      len_wdata = len_rd + rel_len_q;
    end
  end

  bfba_ram #(.WIDTH(FSW), .DEPTH(MAX_BLOCKS)) u_fs_ram (
    .clk_i   (clk_i),
    .we_i    (fs_we),
    .waddr_i (fs_waddr),
    .wdata_i (fs_wdata),
    .raddr_i (raddr),
    .rdata_o (fs_rd)
  );

  bfba_ram #(.WIDTH(LW), .DEPTH(MAX_BLOCKS)) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (len_waddr),
    .wdata_i (len_wdata),
    .raddr_i (raddr),
    .rdata_o (len_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q        <= BC_RESET;
      idx_q       <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) bc_q <= cfg_data_i;
      if (cmd_i.clr_start || cmd_i.srch_start) begin
        idx_q <= '0;
      end else if (cmd_i.clr_step || (cmd_i.mark_step && mark_go)) begin
        idx_q <= idx_q + XW'(1);
      end else if (cmd_i.srch_eval) begin
        idx_q <= idx_q + step;
      end else if (cmd_i.alloc_setup) begin
        idx_q <= XW'(best_start_q);
      end else if (cmd_i.split_setup) begin
        idx_q <= rest;
      end else if (cmd_i.rel_setup) begin
        idx_q <= XW'(b);
      end
      if (cmd_i.take) dcnt_q <= '0;
      else if (cmd_i.div_step) dcnt_q <= dcnt_q + DCW'(1);
      if (cmd_i.load_out) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      op_q   <= op_i;
      zero_q <= (request_bytes_i == '0);
      dvd_q  <= (op_i == OP_RELEASE) ? DW'(release_offset_i) : request_bytes_i;
      rem_q  <= '0;
      quo_q  <= '0;
    end else if (cmd_i.div_step) begin
      if (dcnt_q == '0) quo_q <= quo_nx;
      else rem_q <= RW'(rem_full);
    end
    if (cmd_i.srch_start) begin
      found_q <= 1'b0;
    end else if (cmd_i.srch_eval && cand) begin
      found_q      <= 1'b1;
      best_start_q <= idx_q[IW-1:0];
      best_len_q   <= len_rd;
    end
    if (cmd_i.alloc_setup) begin
      end_q     <= XW'(best_start_q) + XW'(req);
      mk_free_q <= 1'b0;
      mk_base_q <= best_start_q;
    end else if (cmd_i.split_setup) begin
      end_q     <= XW'(best_start_q) + XW'(best_len_q);
      mk_free_q <= 1'b1;
      mk_base_q <= rest[IW-1:0];
    end else if (cmd_i.rel_setup) begin
      end_q     <= XW'(b) + XW'(rel_len_q);
      mk_free_q <= 1'b1;
      mk_base_q <= cmd_i.rel_merge ? base_q : b;
    end
    if (cmd_i.cap_b) begin
      b_free_q  <= fs_rd_free;
      b_start_q <= fs_rd_start;
      rel_len_q <= len_rd;
    end
    if (cmd_i.cap_base) base_q <= fs_rd_start;
    if (cmd_i.set_status) st_q <= cmd_i.status_val;
    if (cmd_i.load_out) begin
      out_status_q <= st_q;
      if ((op_q == OP_ALLOC) && (st_q == ST_OK)) begin
        out_off_q   <= OFF_W'(PW'(best_start_q) * PW'(BLOCK_BYTES));
        out_bytes_q <= GB_W'(PW'(req) * PW'(BLOCK_BYTES));
      end else begin
        out_off_q   <= '0;
        out_bytes_q <= '0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign grant_offset_o = out_off_q;
  assign grant_bytes_o  = out_bytes_q;

endmodule

// ----- hw/rtl/best_fit_block_allocator_unit.sv -----
// A word first has its byte figure turned into blocks (reciprocal multiply, then remainder);
// an allocate then walks the runs for the best fit and marks each block of the granted run
// and of the free remainder split from it; a release marks the blocks of its run free.
// A rejected word skips the walk and the marking.
// Throughput: one word at a time; the next is taken the cycle after the result loads.
// Reset (async, active low) and every register write start a clearing pass over all MAX_BLOCKS
// entries of the map memories, during which no input word is taken.
module best_fit_block_allocator_unit #(
  parameter int unsigned MAX_BLOCKS  = 1024,
  parameter int unsigned BLOCK_BYTES = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // register write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bfba_pkg::BC_W-1:0]     block_count_in_use_i,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bfba_pkg::OP_W-1:0]     op_i,
  input  logic [bfba_pkg::REQ_W-1:0]    request_bytes_i,
  input  logic [bfba_pkg::OFF_W-1:0]    release_offset_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bfba_pkg::ST_W-1:0]     status_o,
  output logic [bfba_pkg::OFF_W-1:0]    grant_offset_o,
  output logic [bfba_pkg::GB_W-1:0]     grant_bytes_o
);
  import bfba_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic cfg_we;

  // Register writes are always taken; they restart the clearing pass.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  // Controller: sequence divide, walk, mark and result hand-off.
  bfba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sts_i      (sts),
    .cfg_we_i   (cfg_we),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  // Datapath: block map memories, divider, best-fit tracking and the
  // result register, which frees the controller while a word waits.
  bfba_datapath #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we),
    .cfg_data_i       (block_count_in_use_i),
    .op_i             (op_i),
    .request_bytes_i  (request_bytes_i),
    .release_offset_i (release_offset_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .status_o         (status_o),
    .grant_offset_o   (grant_offset_o),
    .grant_bytes_o    (grant_bytes_o)
  );

`ifndef SYNTH
  // Hold off new words once one is taken.
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request taken while previous one still in progress");

  // Hold off new words while the map is being rebuilt.
  a_busy_after_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we |=> in_stall_o)
    else $error("request channel open during map rebuild");

  // A failed word carries no grant.
  a_fail_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_OK)) |-> (grant_offset_o == '0 && grant_bytes_o == '0))
    else $error("grant fields set on a failed word");
`endif

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import bfba_pkg::*;

  localparam int unsigned POOL_MAX  = 1024;
  localparam int unsigned BLK_BYTES = 256;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [REQ_W-1:0] req_bytes;
    logic [OFF_W-1:0] rel_off;
  } alloc_word_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [OFF_W-1:0] offset;
    logic [GB_W-1:0]  nbytes;
  } grant_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [BC_W-1:0]  block_count_in_use_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [OP_W-1:0]  op_i = '0;
  logic [REQ_W-1:0] request_bytes_i = '0;
  logic [OFF_W-1:0] release_offset_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [ST_W-1:0]  status_o;
  logic [OFF_W-1:0] grant_offset_o;
  logic [GB_W-1:0]  grant_bytes_o;

  best_fit_block_allocator_unit #(
    .MAX_BLOCKS (POOL_MAX),
    .BLOCK_BYTES(BLK_BYTES)
  ) dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the block map and the register
  bit  blk_free [POOL_MAX];
  int  run_base [POOL_MAX];
  int  run_len  [POOL_MAX];
  int  pool_reg;

  alloc_word_t pending_words[$];
  grant_word_t expected_grants[$];
  int          live_offsets[$];   // offsets of runs currently granted

  int counts [8] = '{1024, 0, 2047, 16, 1, 64, 2, 1024};

  int errors = 0;
  int n_words = 0;
  int n_grants = 0;
  int n_checked = 0;
  int idle_mode = 0;              // 0 none, 1 sender, 2 receiver, 3 both
  bit hold_sender = 1'b0;
  bit hold_go = 1'b0;
  int hold_cnt = 0;

  function automatic int managed_blocks();
    if (pool_reg < 1) return 1;
    if (pool_reg > POOL_MAX) return POOL_MAX;
    return pool_reg;
  endfunction

  function automatic void rebuild_pool_map();
    for (int i = 0; i < POOL_MAX; i++) begin
      blk_free[i] = 1'b1;
      run_base[i] = 0;
      run_len[i]  = 0;
    end
    run_len[0] = managed_blocks();
  endfunction

  function automatic void mark_blocks(bit is_free, int from, int upto, int base);
    for (int i = from; i < upto && i < POOL_MAX; i++) begin
      blk_free[i] = is_free;
      run_base[i] = base;
    end
  endfunction

  // Work out the grant for one word and advance the shadow map
  function automatic grant_word_t predict_grant(alloc_word_t w);
    grant_word_t g;
    int n, need, best_start, best_len, i, len, b, base, rest;
    bit found;
    n = managed_blocks();
    g = '0;
    g.status = ST_OK;
    if (w.op == OP_ALLOC) begin
      need = (int'(w.req_bytes) + BLK_BYTES - 1) / BLK_BYTES;
      if (w.req_bytes == 0 || need > n) begin
        g.status = ST_BAD_REQ;
      end else begin
        found = 1'b0;
        best_start = 0;
        best_len = 0;
        i = 0;
        while (i < n) begin
          len = (run_len[i] == 0) ? 1 : run_len[i];
          if (blk_free[i] && run_len[i] >= need && (!found || run_len[i] < best_len)) begin
            found = 1'b1;
            best_start = i;
            best_len = run_len[i];
          end
          i += len;
        end
        if (!found) begin
          g.status = ST_NO_FIT;
        end else begin
          mark_blocks(1'b0, best_start, best_start + need, best_start);
          run_len[best_start] = need;
          if (best_len > need) begin
            rest = best_start + need;
            mark_blocks(1'b1, rest, best_start + best_len, rest);
            if (rest < POOL_MAX) run_len[rest] = best_len - need;
          end
          g.offset = OFF_W'(best_start * BLK_BYTES);
          g.nbytes = GB_W'(need * BLK_BYTES);
        end
      end
    end else begin
      b = int'(w.rel_off) / BLK_BYTES;
      if ((int'(w.rel_off) % BLK_BYTES) != 0 || b >= n) begin
        g.status = ST_BAD_REL;
      end else if (blk_free[b] || run_base[b] != b) begin
        g.status = ST_BAD_REL;
      end else begin
        len = run_len[b];
        if (b > 0 && blk_free[b-1]) begin
          base = run_base[b-1];
          if (base >= POOL_MAX) base = 0;
          mark_blocks(1'b1, b, b + len, base);
          run_len[base] += len;
        end else begin
          mark_blocks(1'b1, b, b + len, b);
        end
      end
    end
    return g;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on result %0d: %s got %0d want %0d", n_checked, what, got, want);
    errors++;
  endtask

  // Driver: present queued words, drop valid only between words
  always @(posedge clk_i) begin
    alloc_word_t w;
    bit took, idle;
    took = in_valid_i && !in_stall_o;
    if (took) begin
      expected_grants.push_back(predict_grant({op_i, request_bytes_i, release_offset_i}));
      n_words++;
    end
    if (!in_valid_i || took) begin
      idle = hold_sender ||
             (idle_mode == 1 && $urandom_range(99) < 72) ||
             (idle_mode == 3 && $urandom_range(99) < 21);
      if (pending_words.size() != 0 && !idle) begin
        w = pending_words.pop_front();
        op_i <= w.op;
        request_bytes_i <= w.req_bytes;
        release_offset_i <= w.rel_off;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk_i) begin
    if (hold_go) hold_cnt <= 600;
    else if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
  end

  // Monitor: stall at random, check each result word against the oldest grant
  always @(posedge clk_i) begin
    grant_word_t want;
    if (out_valid_o && !out_stall_i) begin
      n_checked++;
      if (expected_grants.size() == 0) begin
        report_mismatch("unexpected word, status", status_o, 0);
      end else begin
        want = expected_grants.pop_front();
        if (status_o != want.status) report_mismatch("status", status_o, want.status);
        if (grant_offset_o != want.offset)
          report_mismatch("grant_offset", grant_offset_o, want.offset);
        if (grant_bytes_o != want.nbytes)
          report_mismatch("grant_bytes", grant_bytes_o, want.nbytes);
        if (want.status == ST_OK && want.nbytes != 0) begin
          live_offsets.push_back(want.offset);
          n_grants++;
        end
      end
    end
    out_stall_i <= (hold_cnt != 0) ||
                   ((idle_mode == 2) && $urandom_range(99) < 72) ||
                   ((idle_mode == 3) && $urandom_range(99) < 21);
  end

  task automatic push_word(bit [OP_W-1:0] op, int nbytes, int off);
    alloc_word_t w;
    w.op = op;
    w.req_bytes = REQ_W'(nbytes);
    w.rel_off = OFF_W'(off);
    pending_words.push_back(w);
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid_i || expected_grants.size() != 0)
      @(posedge clk_i);
  endtask

  // Write the block count while idle and rebuild the shadow map
  task automatic write_block_count(int value);
    wait_drained();
    repeat (40) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    block_count_in_use_i <= BC_W'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    pool_reg = value & 'h7FF;
    rebuild_pool_map();
    live_offsets.delete();
  endtask

  // Mostly well-formed traffic: allocate, then free granted runs; some noise
  task automatic random_words(int count);
    int n, k, pick;
    for (int j = 0; j < count; j++) begin
      while (pending_words.size() > 2) @(posedge clk_i);
      n = managed_blocks();
      pick = $urandom_range(99);
      if (pick < 12) begin
        push_word(OP_W'($urandom_range(1)), $urandom_range(19'h7FFFF),
                  $urandom_range(18'h3FFFF));
      end else if (pick < 55 && live_offsets.size() != 0) begin
        k = $urandom_range(live_offsets.size() - 1);
        push_word(OP_RELEASE, $urandom, live_offsets[k]);
        live_offsets.delete(k);
      end else begin
        push_word(OP_ALLOC, $urandom_range(1, (n * BLK_BYTES + 3) / 4),
                  $urandom_range(18'h3FFFF));
      end
    end
  endtask

  initial begin
    pool_reg = BC_RESET;
    rebuild_pool_map();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: edges of every field, both operations, each error path
    push_word(OP_ALLOC, 0, 0);
    push_word(OP_ALLOC, 'h7FFFF, 0);
    push_word(OP_ALLOC, 1, 0);
    push_word(OP_ALLOC, 256, 0);
    push_word(OP_ALLOC, 257, 'h3FFFF);
    push_word(OP_RELEASE, 0, 1);
    push_word(OP_RELEASE, 0, 'h3FF00);
    push_word(OP_RELEASE, 0, 'h3FFFF);
    push_word(OP_RELEASE, 0, 768);
    push_word(OP_ALLOC, 262144, 0);
    push_word(OP_RELEASE, 0, 0);
    push_word(OP_RELEASE, 'h7FFFF, 256);
    push_word(OP_RELEASE, 0, 0);
    push_word(OP_RELEASE, 0, 512);
    push_word(OP_ALLOC, 262144, 0);
    push_word(OP_RELEASE, 0, 0);
    push_word(OP_ALLOC, 300, 0);
    push_word(OP_ALLOC, 262144 - 512, 0);
    wait_drained();
    live_offsets.delete();

    for (int p = 0; p < 8; p++) begin
      write_block_count(counts[p]);
      idle_mode = p % 4;
      random_words(35);
      if (p == 2) begin
        hold_go <= 1'b1;
        @(posedge clk_i);
        hold_go <= 1'b0;
      end
      if (p == 4) begin
        // pause until every outstanding grant has come back
        hold_sender = 1'b1;
        while (in_valid_i || expected_grants.size() != 0) @(posedge clk_i);
        hold_sender = 1'b0;
      end
      random_words(35);
    end

    wait_drained();
    repeat (3200) @(posedge clk_i);
    $display("covered %0d words, %0d results checked, %0d runs granted, 9 block counts",
             n_words, n_checked, n_grants);
    if (errors == 0 && expected_grants.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #400ms;
    $display("timeout with %0d results outstanding", expected_grants.size());
    $display("FAIL");
    $finish;
  end

endmodule
